// ===== rtl/msrf_pkg.sv =====
// Package for the system register file: request and response types, register
// selector and action codes, reset defaults and the write-port structure.
// Used by every module under rtl/.
package msrf_pkg;

	localparam int NUM_STORED = 22;
	localparam int SEL_W      = 5;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int ALIGN_W    = 5;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_READ_FX  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_FX = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RAW_RD   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RAW_WR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

	// Register selectors.
	localparam logic [SEL_W-1:0] SEL_XPSR        = 5'd0;
	localparam logic [SEL_W-1:0] SEL_MSP         = 5'd1;
	localparam logic [SEL_W-1:0] SEL_PSP         = 5'd2;
	localparam logic [SEL_W-1:0] SEL_CONTROL     = 5'd3;
	localparam logic [SEL_W-1:0] SEL_BASEPRI     = 5'd5;
	localparam logic [SEL_W-1:0] SEL_CPUID       = 5'd7;
	localparam logic [SEL_W-1:0] SEL_VTOR        = 5'd8;
	localparam logic [SEL_W-1:0] SEL_AIRCR       = 5'd9;
	localparam logic [SEL_W-1:0] SEL_CCR         = 5'd11;
	localparam logic [SEL_W-1:0] SEL_CFSR        = 5'd16;
	localparam logic [SEL_W-1:0] SEL_HFSR        = 5'd17;
	localparam logic [SEL_W-1:0] SEL_DFSR        = 5'd18;
	localparam logic [SEL_W-1:0] SEL_LAST_STORED = 5'd21;
	localparam logic [SEL_W-1:0] SEL_BASEPRI_MAX = 5'd22;
	localparam logic [SEL_W-1:0] SEL_CPSR        = 5'd23;
	localparam logic [SEL_W-1:0] SEL_CPSR_Q      = 5'd24;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CPUID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 1'b1;

	localparam logic [31:0]        XPSR_RESET   = 32'h0100_0000;
	localparam logic [31:0]        AIRCR_RESET  = 32'hFA05_0000;
	localparam logic [31:0]        CCR_RESET    = 32'h0000_0200;
	localparam logic [31:0]        CPSR_FIELDS  = 32'hFE0F_FC00;
	localparam logic [15:0]        AIRCR_WKEY   = 16'h05FA;
	localparam logic [15:0]        AIRCR_RKEY   = 16'hFA05;
	localparam int                 Q_BIT        = 27;
	localparam logic [ALIGN_W-1:0] ALIGN_MIN    = 5'd7;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [SEL_W-1:0] reg_sel;
		logic [31:0]      write_value;
		logic             thumb_state;
		logic [31:0]      current_sp;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        sp_load;
		logic [31:0] sp_value;
		logic        user_mode;
		logic        bad_index;
	} rsp_t;

	typedef struct packed {
		logic             en;
		logic [SEL_W-1:0] addr;
		logic [31:0]      data;
	} store_wr_t;

	typedef struct packed {
		store_wr_t   wr;
		logic        clr;
		logic [31:0] xpsr_nxt;
		logic [31:0] control_nxt;
		rsp_t        rsp;
	} exec_t;

	// Value of a stored entry that has not been written since the last clear.
	function automatic logic [31:0] default_value(input logic [SEL_W-1:0] idx,
		input logic [31:0] cpuid);
		logic [31:0] val;
		unique case (idx)
			SEL_XPSR:  val = XPSR_RESET;
			SEL_CPUID: val = cpuid;
			SEL_AIRCR: val = AIRCR_RESET;
			SEL_CCR:   val = CCR_RESET;
			default:   val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== rtl/msrf_store.sv =====
// Register store: a 22-entry synchronous memory with a registered read port,
// one write port and per-entry valid bits, so a clear need only reset those.
// Depends on msrf_pkg.
module msrf_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [msrf_pkg::SEL_W-1:0] rd_addr,
	output logic [31:0]               rd_data,
	input  msrf_pkg::store_wr_t       wr,
	input  logic                      clr,
	input  logic [31:0]               cpuid
);
	import msrf_pkg::*;

	logic [31:0]           mem [NUM_STORED];
	logic [NUM_STORED-1:0] vld_q;
	logic [31:0]           cpuid_q;
	logic [31:0]           rdat_s1;
	logic                  rvld_s1;
	logic [SEL_W-1:0]      raddr_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdat_s1  <= mem[rd_addr];
			raddr_s1 <= rd_addr;
		end
	end

	// The CPUID default is captured when the clear happens, not when it is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			cpuid_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (clr) begin
				vld_q   <= '0;
				cpuid_q <= cpuid;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_s1 ? rdat_s1 : default_value(raddr_s1, cpuid_q);

endmodule

// ===== rtl/msrf_exec.sv =====
// Access logic: works out the read data, the store write-back, the new xPSR
// and CONTROL values and the stack exchange for one request.
// Depends on msrf_pkg.
module msrf_exec (
	input  msrf_pkg::req_t               item,
	input  logic [31:0]                  rdat,
	input  logic [31:0]                  xpsr,
	input  logic [31:0]                  control,
	input  logic [msrf_pkg::ALIGN_W-1:0] align,
	output msrf_pkg::exec_t              ex
);
	import msrf_pkg::*;

	logic [ALIGN_W-1:0] align_eff;
	logic [31:0]        vtor_mask;
	logic [31:0]        v;
	logic [SEL_W-1:0]   sel;
	logic               sp_switch;

	assign v         = item.write_value;
	assign sel       = item.reg_sel;
	assign align_eff = (align < ALIGN_MIN) ? ALIGN_MIN : align;
	assign vtor_mask = ~((32'd1 << align_eff) - 32'd1);
	assign sp_switch = (xpsr[8:0] == 9'd0) && (control[1] != v[1]);

	always_comb begin
		ex             = '0;
		ex.xpsr_nxt    = xpsr;
		ex.control_nxt = control;
		ex.wr.addr     = sel;
		ex.wr.data     = v;
		unique case (item.action)
			ACT_READ_FX: begin
				if (sel > SEL_CPSR_Q) begin
					ex.rsp.bad_index = 1'b1;
				end else if (sel == SEL_XPSR) begin
					ex.rsp.read_value = {xpsr[31:25], item.thumb_state, xpsr[23:0]};
				end else if (sel == SEL_CONTROL) begin
					ex.rsp.read_value = control;
				end else if (sel == SEL_CPSR) begin
					ex.rsp.read_value = (xpsr & CPSR_FIELDS) |
						{26'd0, item.thumb_state, 5'd0};
				end else if (sel == SEL_CPSR_Q) begin
					ex.rsp.read_value = '0;
				end else begin
					// BASEPRI_MAX was read from the BASEPRI entry.
					ex.rsp.read_value = rdat;
				end
			end
			ACT_WRITE_FX: begin
				unique case (sel)
					SEL_XPSR: ex.xpsr_nxt = v;
					SEL_CONTROL: begin
						ex.control_nxt = v;
						if (sp_switch) begin
							// Save the live SP to the old stack; the new one was read.
							ex.wr.en        = 1'b1;
							ex.wr.addr      = control[1] ? SEL_PSP : SEL_MSP;
							ex.wr.data      = item.current_sp;
							ex.rsp.sp_load  = 1'b1;
							ex.rsp.sp_value = rdat;
						end
					end
					SEL_CPUID: ;
					SEL_VTOR: begin
						ex.wr.en   = 1'b1;
						ex.wr.data = v & vtor_mask;
					end
					SEL_AIRCR: begin
						ex.wr.en   = (v[31:16] == AIRCR_WKEY);
						ex.wr.data = {AIRCR_RKEY, v[15:0]};
					end
					SEL_CFSR, SEL_HFSR, SEL_DFSR: begin
						ex.wr.en   = 1'b1;
						ex.wr.data = rdat & ~v;
					end
					SEL_BASEPRI_MAX: begin
						ex.wr.addr = SEL_BASEPRI;
						ex.wr.en   = (v != 32'd0) && ((rdat == 32'd0) || (v < rdat));
					end
					SEL_CPSR: ex.xpsr_nxt = (xpsr & ~CPSR_FIELDS) | (v & CPSR_FIELDS);
					SEL_CPSR_Q: ex.xpsr_nxt = xpsr | (v & (32'd1 << Q_BIT));
					default: begin
						if (sel > SEL_CPSR_Q) begin
							ex.rsp.bad_index = 1'b1;
						end else begin
							ex.wr.en = 1'b1;
						end
					end
				endcase
			end
			ACT_RAW_RD: begin
				if (sel > SEL_LAST_STORED) begin
					ex.rsp.bad_index = 1'b1;
				end else if (sel == SEL_XPSR) begin
					ex.rsp.read_value = xpsr;
				end else if (sel == SEL_CONTROL) begin
					ex.rsp.read_value = control;
				end else begin
					ex.rsp.read_value = rdat;
				end
			end
			ACT_RAW_WR: begin
				if (sel > SEL_LAST_STORED) begin
					ex.rsp.bad_index = 1'b1;
				end else if (sel == SEL_XPSR) begin
					ex.xpsr_nxt = v;
				end else if (sel == SEL_CONTROL) begin
					ex.control_nxt = v;
				end else begin
					ex.wr.en = 1'b1;
				end
			end
			ACT_CLEAR: begin
				ex.clr         = 1'b1;
				ex.xpsr_nxt    = XPSR_RESET;
				ex.control_nxt = '0;
			end
			default: ;
		endcase
		ex.rsp.user_mode = (ex.xpsr_nxt[8:0] == 9'd0) && ex.control_nxt[0];
	end

endmodule

// ===== rtl/mprofile_system_register_file_top.sv =====
// Top level of the system register file: request channel, response register,
// configuration registers, xPSR and CONTROL, and the two-state sequencer.
// Depends on msrf_pkg, msrf_store and msrf_exec.
//
// Usage
// A request (action, selector, write data, Thumb state, live SP) is taken on
// the req channel when req_valid is high and req_stall low. Every request
// gives exactly one response on the rsp channel, in order.
// In the cycle of acceptance the store entry that a request needs is addressed;
// then, in the EXEC state, the registered read data is modified, written back
// and the response is loaded into the output register. The single store port
// and its registered read mean that no new request is taken while one is in
// its EXEC state. If the receiver stalls with a response still held, the next
// request is still accepted and waits in EXEC until the output register frees
// up. The user writes configuration through cfg_we/cfg_index/cfg_data only
// while no request is in flight; the block itself does not enforce this. Reset
// loads the documented defaults, with CPUID zero; a clear request reloads them
// with CPUID from the configured CPUID word (cfg_index CFG_CPUID).
module mprofile_system_register_file_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  msrf_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output msrf_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [msrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import msrf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic               state_q;
	req_t               item_q;
	logic [31:0]        xpsr_q;
	logic [31:0]        control_q;
	logic [31:0]        cpuid_cfg_q;
	logic [ALIGN_W-1:0] align_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               done;
	logic [SEL_W-1:0]   rd_addr;
	logic [31:0]        rdat;
	exec_t              ex;
	store_wr_t          st_wr;

	assign req_stall = (state_q == ST_EXEC);
	assign accept    = req_valid && !req_stall;
	assign done      = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Pick the entry that the EXEC state will need.
	always_comb begin
		priority if (req.reg_sel == SEL_BASEPRI_MAX) begin
			rd_addr = SEL_BASEPRI;
		end else if (req.action == ACT_WRITE_FX && req.reg_sel == SEL_CONTROL) begin
			rd_addr = req.write_value[1] ? SEL_PSP : SEL_MSP;
		end else if (req.reg_sel <= SEL_LAST_STORED) begin
			rd_addr = req.reg_sel;
		end else begin
			rd_addr = SEL_XPSR;
		end
	end

	always_comb begin
		st_wr    = ex.wr;
		st_wr.en = ex.wr.en && done;
	end

	msrf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rdat),
		.wr      (st_wr),
		.clr     (ex.clr && done),
		.cpuid   (cpuid_cfg_q)
	);

	msrf_exec u_exec (
		.item    (item_q),
		.rdat    (rdat),
		.xpsr    (xpsr_q),
		.control (control_q),
		.align   (align_q),
		.ex      (ex)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (done) begin
			rsp_q <= ex.rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			xpsr_q      <= XPSR_RESET;
			control_q   <= '0;
			cpuid_cfg_q <= '0;
			align_q     <= ALIGN_MIN;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CPUID: cpuid_cfg_q <= cfg_data;
					CFG_ALIGN: align_q     <= cfg_data[ALIGN_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (done) begin
				xpsr_q      <= ex.xpsr_nxt;
				control_q   <= ex.control_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The privilege flag always matches the state that the response left behind.
	a_user_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.user_mode == ((xpsr_q[8:0] == 9'd0) && control_q[0]))
		else $error("user_mode does not match xPSR and CONTROL");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC) && req_stall)
		else $error("accepted request did not enter its second cycle");

	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> rsp_valid && (state_q == ST_IDLE))
		else $error("finished request did not produce a response");

	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> (rsp.read_value == 32'd0) && !rsp.sp_load)
		else $error("unmodelled selector returned data or an SP load");

	a_sp_load: assert property (@(posedge clk) disable iff (!arst_n)
		done && ex.rsp.sp_load |-> (item_q.action == ACT_WRITE_FX) &&
			(item_q.reg_sel == SEL_CONTROL) && ex.wr.en)
		else $error("SP load without a CONTROL write saving the old stack");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the M-profile system register file: a directed table,
// then random register accesses over several configurations, checked against a predictor.
// Depends on msrf_pkg and mprofile_system_register_file_top.
module testbench;
	import msrf_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 500;
	localparam int NUM_PHASES   = 4;
	localparam int MAX_IDLE     = 17;
	localparam int HOLD_OFF     = 120;
	localparam int PRINT_CAP    = 100;
	localparam logic [31:0]      DIR_CPUID      = 32'h4A5B_C3D1;
	localparam logic [ACT_W-1:0] ACT_UNDEF_TOP  = '1;
	localparam logic [SEL_W-1:0] SEL_UNMOD_TOP  = '1;
	localparam logic [ALIGN_W-1:0] ALIGN_TOP    = '1;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;

	// Predictor state: stored registers and configuration.
	logic [31:0]        shadow_regs [NUM_STORED];
	logic [31:0]        cpuid_cfg;
	logic [ALIGN_W-1:0] align_cfg;

	rsp_t     due_rsps[$];
	dir_row_t dir_tab[$];
	int       errors, sent, checked, exchanges, bad_hits, cycles;
	bit       req_calm, rsp_calm;

	mprofile_system_register_file_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("run stopped after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("mismatch at response %0d: %s got %h want %h", checked, what, got, want);
	endtask

	function automatic void load_defaults();
		for (int i = 0; i < NUM_STORED; i++)
			shadow_regs[i] = '0;
		shadow_regs[SEL_XPSR]  = XPSR_RESET;
		shadow_regs[SEL_CPUID] = cpuid_cfg;
		shadow_regs[SEL_AIRCR] = AIRCR_RESET;
		shadow_regs[SEL_CCR]   = CCR_RESET;
	endfunction

	// Carries out one access on the shadow registers and returns its response.
	function automatic rsp_t apply_sysreg_access(input req_t rq);
		rsp_t               r;
		logic [31:0]        v, xpsr;
		logic [ALIGN_W-1:0] sh;
		logic               olds, news, keep;
		r    = '0;
		v    = rq.write_value;
		xpsr = shadow_regs[SEL_XPSR];
		keep = 1'b1;
		case (rq.action)
			ACT_READ_FX: begin
				if (rq.reg_sel > SEL_CPSR_Q)
					r.bad_index = 1'b1;
				else if (rq.reg_sel == SEL_XPSR)
					r.read_value = {xpsr[31:25], rq.thumb_state, xpsr[23:0]};
				else if (rq.reg_sel == SEL_BASEPRI_MAX)
					r.read_value = shadow_regs[SEL_BASEPRI];
				else if (rq.reg_sel == SEL_CPSR)
					r.read_value = (xpsr & CPSR_FIELDS) | {26'd0, rq.thumb_state, 5'd0};
				else if (rq.reg_sel != SEL_CPSR_Q)
					r.read_value = shadow_regs[rq.reg_sel];
			end
			ACT_WRITE_FX: begin
				if (rq.reg_sel > SEL_CPSR_Q) begin
					r.bad_index = 1'b1;
					keep = 1'b0;
				end else begin
					case (rq.reg_sel)
						SEL_VTOR: begin
							sh = (align_cfg < ALIGN_MIN) ? ALIGN_MIN : align_cfg;
							v  = v & ~((32'd1 << sh) - 32'd1);
						end
						SEL_CFSR, SEL_HFSR, SEL_DFSR:
							v = shadow_regs[rq.reg_sel] & ~v;
						SEL_AIRCR: begin
							if (v[31:16] != AIRCR_WKEY)
								keep = 1'b0;
							else
								v = {AIRCR_RKEY, v[15:0]};
						end
						SEL_BASEPRI_MAX: begin
							keep = 1'b0;
							if (v != '0 && (shadow_regs[SEL_BASEPRI] == '0 ||
								v < shadow_regs[SEL_BASEPRI]))
								shadow_regs[SEL_BASEPRI] = v;
						end
						SEL_CPSR_Q: begin
							keep = 1'b0;
							shadow_regs[SEL_XPSR][Q_BIT] = xpsr[Q_BIT] | v[Q_BIT];
						end
						SEL_CPSR: begin
							keep = 1'b0;
							shadow_regs[SEL_XPSR] = (xpsr & ~CPSR_FIELDS) | (v & CPSR_FIELDS);
						end
						SEL_CPUID:
							keep = 1'b0;
						SEL_CONTROL: begin
							// Thread mode with a change of stack select swaps the live SP.
							olds = shadow_regs[SEL_CONTROL][1];
							news = v[1];
							if (xpsr[8:0] == '0 && olds != news) begin
								shadow_regs[olds ? SEL_PSP : SEL_MSP] = rq.current_sp;
								r.sp_load  = 1'b1;
								r.sp_value = shadow_regs[news ? SEL_PSP : SEL_MSP];
							end
						end
						default: ;
					endcase
					if (keep)
						shadow_regs[rq.reg_sel] = v;
				end
			end
			ACT_RAW_RD: begin
				if (rq.reg_sel > SEL_LAST_STORED)
					r.bad_index = 1'b1;
				else
					r.read_value = shadow_regs[rq.reg_sel];
			end
			ACT_RAW_WR: begin
				if (rq.reg_sel > SEL_LAST_STORED)
					r.bad_index = 1'b1;
				else
					shadow_regs[rq.reg_sel] = rq.write_value;
			end
			ACT_CLEAR:
				load_defaults();
			default: ;
		endcase
		r.user_mode = (shadow_regs[SEL_XPSR][8:0] == '0) && shadow_regs[SEL_CONTROL][0];
		return r;
	endfunction

	function automatic rsp_t answer(input logic [31:0] rd, input logic ld,
		input logic [31:0] spv, input logic um, input logic bad);
		return {rd, ld, spv, um, bad};
	endfunction

	function automatic void add_row(input logic [ACT_W-1:0] act, input logic [SEL_W-1:0] sel,
		input logic [31:0] wv, input logic thumb, input logic [31:0] sp,
		input bit typed, input rsp_t want);
		dir_row_t row;
		row.rq    = {act, sel, wv, thumb, sp};
		row.typed = typed;
		row.want  = want;
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	// Write data shaped by register, so that thread mode, the key check and
	// the raise-only rule are reached often.
	function automatic logic [31:0] random_write_value(input logic [SEL_W-1:0] sel);
		logic [31:0] v;
		int unsigned pick;
		v    = $urandom;
		pick = $urandom_range(0, 99);
		case (sel)
			SEL_XPSR:
				if (pick < 60) v[8:0] = '0;
			SEL_CONTROL:
				if (pick < 50) v = v & 32'h3;
			SEL_AIRCR:
				if (pick < 50) v[31:16] = AIRCR_WKEY;
			SEL_BASEPRI, SEL_BASEPRI_MAX:
				if (pick < 70) v = $urandom_range(0, 255);
			default: begin
				if (pick < 10)
					v = '0;
				else if (pick < 20)
					v = '1;
			end
		endcase
		return v;
	endfunction

	function automatic req_t random_request();
		req_t rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			rq.action = ACT_READ_FX;
		else if (pick < 64)
			rq.action = ACT_WRITE_FX;
		else if (pick < 77)
			rq.action = ACT_RAW_RD;
		else if (pick < 93)
			rq.action = ACT_RAW_WR;
		else if (pick < 96)
			rq.action = ACT_CLEAR;
		else
			rq.action = ACT_W'($urandom_range(ACT_CLEAR + 1, ACT_UNDEF_TOP));
		pick = $urandom_range(0, 99);
		if (pick < 12)
			rq.reg_sel = SEL_CONTROL;
		else if (pick < 20)
			rq.reg_sel = SEL_XPSR;
		else if (pick < 90)
			rq.reg_sel = SEL_W'($urandom_range(SEL_XPSR, SEL_CPSR_Q));
		else
			rq.reg_sel = SEL_W'($urandom_range(SEL_CPSR_Q + 1, SEL_UNMOD_TOP));
		rq.write_value = random_write_value(rq.reg_sel);
		rq.thumb_state = 1'($urandom_range(0, 1));
		rq.current_sp  = $urandom;
		return rq;
	endfunction

	function automatic int unsigned idle_draw(input bit calm);
		return calm ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	task automatic set_phase_config(input logic [31:0] cpuid, input logic [ALIGN_W-1:0] align);
		logic [31-ALIGN_W:0] junk_hi;
		junk_hi   = (32-ALIGN_W)'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CPUID;
		cfg_data  <= cpuid;
		@(posedge clk);
		cfg_index <= CFG_ALIGN;
		cfg_data  <= {junk_hi, align};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cpuid_cfg = cpuid;
		align_cfg = align;
	endtask

	task automatic drive_request(input req_t rq, input bit typed, input rsp_t want);
		int unsigned gap;
		rsp_t predicted;
		if ($urandom_range(0, 39) == 0)
			req_calm = !req_calm;
		gap = idle_draw(req_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= rq;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predicted = apply_sysreg_access(rq);
		due_rsps.insert(due_rsps.size(), typed ? want : predicted);
		sent++;
	endtask

	initial begin
		int unsigned hold;
		int          taken;
		rsp_t        want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rsp_calm = !rsp_calm;
			// Twice in the run the receiver backs off long enough for back-pressure to reach the requests.
			hold = (taken == 300 || taken == 1300) ? HOLD_OFF : idle_draw(rsp_calm);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!rsp_valid);
			taken++;
			if (due_rsps.size() == 0) begin
				note_mismatch("unexpected response, read_value", rsp.read_value, '0);
			end else begin
				want = due_rsps.pop_front();
				if (rsp.read_value !== want.read_value)
					note_mismatch("read_value", rsp.read_value, want.read_value);
				if (rsp.sp_load !== want.sp_load)
					note_mismatch("sp_load", 32'(rsp.sp_load), 32'(want.sp_load));
				if (rsp.sp_value !== want.sp_value)
					note_mismatch("sp_value", rsp.sp_value, want.sp_value);
				if (rsp.user_mode !== want.user_mode)
					note_mismatch("user_mode", 32'(rsp.user_mode), 32'(want.user_mode));
				if (rsp.bad_index !== want.bad_index)
					note_mismatch("bad_index", 32'(rsp.bad_index), 32'(want.bad_index));
				exchanges += int'(want.sp_load);
				bad_hits  += int'(want.bad_index);
			end
			checked++;
		end
	end

	initial begin
		cpuid_cfg = '0;
		align_cfg = ALIGN_MIN;
		load_defaults();

		// CPUID only picks up the configured word on a clear.
		add_row(ACT_RAW_RD,   SEL_CPUID, '0, 1'b0, '0, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_CLEAR,    SEL_XPSR,  '1, 1'b1, '1, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_RAW_RD,   SEL_CPUID, '0, 1'b1, '0, 1'b1,
			answer(DIR_CPUID, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_CPUID, '1, 1'b0, '0, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_READ_FX,  SEL_XPSR,  '0, 1'b0, '0, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_VTOR,  '1, 1'b0, '0, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_RAW_RD,   SEL_VTOR,  '0, 1'b0, '0, 1'b1,
			answer(32'h8000_0000, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_AIRCR, 32'h1234_0004, 1'b0, '0, 1'b0, '0);
		add_row(ACT_WRITE_FX, SEL_AIRCR, 32'h05FA_0004, 1'b0, '0, 1'b0, '0);
		add_row(ACT_RAW_RD,   SEL_AIRCR, '0, 1'b0, '0, 1'b1,
			answer(32'hFA05_0004, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_RAW_WR,   SEL_CFSR,  '1, 1'b0, '0, 1'b0, '0);
		add_row(ACT_WRITE_FX, SEL_CFSR,  32'h0000_FFFF, 1'b0, '0, 1'b0, '0);
		add_row(ACT_RAW_RD,   SEL_CFSR,  '0, 1'b0, '0, 1'b1,
			answer(32'hFFFF_0000, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_BASEPRI_MAX, 32'h40, 1'b0, '0, 1'b0, '0);
		add_row(ACT_WRITE_FX, SEL_BASEPRI_MAX, 32'h80, 1'b0, '0, 1'b0, '0);
		add_row(ACT_READ_FX,  SEL_BASEPRI_MAX, '0, 1'b0, '0, 1'b1,
			answer(32'h40, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_CPSR,  '1, 1'b1, '0, 1'b0, '0);
		add_row(ACT_READ_FX,  SEL_CPSR,  '0, 1'b1, '0, 1'b0, '0);
		add_row(ACT_RAW_WR,   SEL_XPSR,  '0, 1'b0, '0, 1'b0, '0);
		add_row(ACT_WRITE_FX, SEL_CPSR_Q, '1, 1'b0, '0, 1'b0, '0);
		add_row(ACT_READ_FX,  SEL_CPSR_Q, '0, 1'b0, '0, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_RAW_RD,   SEL_XPSR,  '0, 1'b0, '0, 1'b1,
			answer(32'h0800_0000, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_WRITE_FX, SEL_CONTROL, 32'h3, 1'b0, 32'hDEAD_BEE0, 1'b1,
			answer('0, 1'b1, '0, 1'b1, 1'b0));
		add_row(ACT_RAW_WR,   SEL_CONTROL, '0, 1'b0, '1, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));
		add_row(ACT_READ_FX,  SEL_UNMOD_TOP, '1, 1'b1, '1, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b1));
		add_row(ACT_UNDEF_TOP, SEL_XPSR, '1, 1'b1, '1, 1'b1,
			answer('0, 1'b0, '0, 1'b0, 1'b0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_phase_config(DIR_CPUID, ALIGN_TOP);
				1: set_phase_config('1, '0);
				2: set_phase_config('0, ALIGN_MIN);
				default: set_phase_config($urandom,
					ALIGN_W'($urandom_range(ALIGN_MIN + 1, ALIGN_TOP - 1)));
			endcase
			if (ph == 0)
				foreach (dir_tab[i])
					drive_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
			repeat (PHASE_ITEMS)
				drive_request(random_request(), 1'b0, '0);
			req_valid <= 1'b0;
			while (due_rsps.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end

		$display("run covered %0d requests, %0d of them from the directed table, under %0d settings",
			sent, dir_tab.size(), NUM_PHASES);
		$display("%0d responses compared: %0d stack exchanges, %0d unmodelled selectors",
			checked, exchanges, bad_hits);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
